// File: design/twdf_pkg.sv
// Shared types, codes and constants of the timed waypoint drive follower.
// Used by the controller, the datapath and the top level; no dependencies.
package twdf_pkg;

	localparam int MAX_WAYPOINTS = 64;
	localparam int IDX_W = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W = IDX_W + 1;

	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS = 25;
	localparam int RAD_W = 2 * SQRT_STEPS;
	localparam int ROOT_W = SQRT_STEPS;
	localparam int REM_W = ROOT_W + 3;
	localparam int DIV_W = 48;
	localparam int CX_W = 32;
	localparam int Z_W = 25;
	localparam int STEP_W = 6;

	localparam logic [20:0] SPEED_SCALE = 21'd1536000;
	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
	localparam logic [9:0] MS_PER_S = 10'd1000;
	localparam logic signed [Z_W-1:0] Z_MAX = 25'sd2304000;
	localparam logic [19:0] SAT_HI = 20'd524287;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [2:0] RES_IDLE = 3'd0;
	localparam logic [2:0] RES_TURN = 3'd1;
	localparam logic [2:0] RES_DRIVE = 3'd2;
	localparam logic [2:0] RES_DONE = 3'd3;
	localparam logic [2:0] RES_REJECT = 3'd4;

	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_GAIN = 2'd1;
	localparam logic [1:0] CFG_TOL = 2'd2;

	localparam logic [9:0] RADIUS_RST = 10'd50;
	localparam logic [7:0] GAIN_RST = 8'd48;
	localparam logic [13:0] TOL_RST = 14'd300;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] wp_time_s;
		logic signed [15:0] wp_x_mm;
		logic signed [15:0] wp_y_mm;
		logic [15:0] heading_cdeg;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [19:0] left_drive;
		logic signed [19:0] right_drive;
		logic [2:0] status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_RD_P, ST_RD_Q, ST_PREP, ST_SQ, ST_CALC, ST_MUL1,
		ST_MUL2, ST_MUL3, ST_DIV_INIT, ST_DIV, ST_SPEED, ST_STEER, ST_POWER, ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic do_load;
		logic do_start;
		logic do_advance;
		logic do_done;
		logic rd_p;
		logic rd_q;
		logic prep;
		logic sq;
		logic calc;
		logic mul1;
		logic mul2;
		logic mul3;
		logic div_init;
		logic div_step;
		logic speed;
		logic steer;
		logic power;
		logic set_code;
		logic code_steer;
		logic [2:0] code;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic running;
		logic done;
		logic load_ok;
		logic start_ok;
		logic reached;
		logic at_end;
		logic sqrt_last;
		logic div_last;
		logic out_busy;
	} sts_t;

	function automatic logic [20:0] atan_entry(input logic [3:0] i);
		case (i)
			4'd0: atan_entry = 21'd1152000;
			4'd1: atan_entry = 21'd680065;
			4'd2: atan_entry = 21'd359328;
			4'd3: atan_entry = 21'd182400;
			4'd4: atan_entry = 21'd91554;
			4'd5: atan_entry = 21'd45822;
			4'd6: atan_entry = 21'd22916;
			4'd7: atan_entry = 21'd11459;
			4'd8: atan_entry = 21'd5730;
			4'd9: atan_entry = 21'd2865;
			4'd10: atan_entry = 21'd1432;
			4'd11: atan_entry = 21'd716;
			4'd12: atan_entry = 21'd358;
			4'd13: atan_entry = 21'd179;
			4'd14: atan_entry = 21'd90;
			default: atan_entry = 21'd45;
		endcase
	endfunction

endpackage

// File: design/timed_waypoint_drive_follower_core.sv
// Top level of the timed waypoint drive follower: controller plus datapath.
// Depends on twdf_pkg, twdf_ctrl and twdf_dp.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_item (in_item_t)
//  out      output     out_valid/out_ready  out_item (out_item_t)
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// Loads, rejects, idle and done ticks go from EXEC straight to OUT; ticks within a segment
// pass STEER and POWER first. A start, and a tick that opens a new segment, also run the
// 25-step square root (CORDIC runs alongside) and the 48-step restoring divider.
// One item is in work at a time; the next is taken while a result waits.
// Reset is asynchronous; no clearing pass, the waypoint memory is never swept.
module timed_waypoint_drive_follower_core import twdf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [13:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	twdf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	twdf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_item(in_item),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule

// File: design/twdf_ctrl.sv
// Controller state machine of the waypoint follower.
// Depends on twdf_pkg; drives the datapath by cmd_t and reads its sts_t.
module twdf_ctrl import twdf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (sts.req_type)
					REQ_START: state_d = sts.start_ok ? ST_RD_P : ST_OUT;
					REQ_TICK: begin
						if (sts.running && !sts.done && sts.reached && !sts.at_end)
							state_d = ST_RD_P;
						else if (sts.running && !sts.done && !sts.reached)
							state_d = ST_STEER;
						else
							state_d = ST_OUT;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_RD_P: state_d = ST_RD_Q;
			ST_RD_Q: state_d = ST_PREP;
			ST_PREP: state_d = ST_SQ;
			ST_SQ: state_d = ST_CALC;
			ST_CALC: begin
				if (sts.sqrt_last) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) state_d = ST_SPEED;
			end
			ST_SPEED: state_d = (sts.req_type == REQ_TICK) ? ST_STEER : ST_OUT;
			ST_STEER: state_d = ST_POWER;
			ST_POWER: state_d = ST_OUT;
			ST_OUT: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE);
		cmd.capture = in_valid && (state_q == ST_IDLE);
		case (state_q)
			ST_EXEC: begin
				case (sts.req_type)
					REQ_LOAD: begin
						cmd.set_code = 1'b1;
						cmd.code = sts.load_ok ? RES_IDLE : RES_REJECT;
						cmd.do_load = sts.load_ok;
					end
					REQ_START: begin
						cmd.set_code = 1'b1;
						cmd.code = sts.start_ok ? RES_IDLE : RES_REJECT;
						cmd.do_start = sts.start_ok;
					end
					REQ_TICK: begin
						if (!sts.running) begin
							cmd.set_code = 1'b1;
							cmd.code = RES_IDLE;
						end else if (sts.done) begin
							cmd.set_code = 1'b1;
							cmd.code = RES_DONE;
						end else if (sts.reached) begin
							if (sts.at_end) begin
								cmd.do_done = 1'b1;
								cmd.set_code = 1'b1;
								cmd.code = RES_DONE;
							end else begin
								cmd.do_advance = 1'b1;
							end
						end
					end
					default: begin
						cmd.set_code = 1'b1;
						cmd.code = RES_REJECT;
					end
				endcase
			end
			ST_RD_P: cmd.rd_p = 1'b1;
			ST_RD_Q: cmd.rd_q = 1'b1;
			ST_PREP: cmd.prep = 1'b1;
			ST_SQ: cmd.sq = 1'b1;
			ST_CALC: cmd.calc = 1'b1;
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_MUL3: cmd.mul3 = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_SPEED: cmd.speed = 1'b1;
			ST_STEER: cmd.steer = 1'b1;
			ST_POWER: begin
				cmd.power = 1'b1;
				cmd.set_code = 1'b1;
				cmd.code_steer = 1'b1;
			end
			ST_OUT: cmd.res_load = !sts.out_busy;
			default: cmd.res_load = 1'b0;
		endcase
	end

endmodule

// File: design/twdf_dp.sv
// Datapath of the waypoint follower: registers, waypoint memory, CORDIC,
// square root, divider and steering arithmetic. Depends on twdf_pkg.
module twdf_dp import twdf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [13:0] cfg_data,
	input in_item_t in_item,
	input cmd_t cmd,
	output sts_t sts,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item
);

	in_item_t item_q;
	logic [9:0] radius_q;
	logic [7:0] gain_q;
	logic [13:0] tol_q;

	logic [47:0] mem [MAX_WAYPOINTS];
	logic [47:0] rd_q;
	logic [IDX_W-1:0] rd_addr;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] tgt_q;
	logic [15:0] last_t_q;
	logic [31:0] start_q;
	logic [15:0] bearing_q;
	logic [19:0] speed_q;
	logic reversed_q, running_q, done_q;

	logic [47:0] p_q;
	logic [15:0] ax_q, ay_q, dur_q;
	logic dxneg_q, dyneg_q;
	logic [26:0] tms_q;

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic signed [CX_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0] cz_q;
	logic [STEP_W-1:0] cnt_q;

	logic [45:0] num_q;
	logic [28:0] rr_q;
	logic [44:0] den_q;
	logic [DIV_W-1:0] dvd_q, quo_q;
	logic [DIV_W:0] drem_q;

	logic signed [14:0] err_q;
	logic drive_q;
	logic signed [19:0] power_q;
	logic [2:0] code_q;
	logic steer_q;

	logic signed [16:0] dx_c, dy_c, ax_c, ay_c;
	logic [REM_W-1:0] srem_sh, strial;
	logic signed [CX_W-1:0] xs_c, ys_c;
	logic signed [Z_W-1:0] atan_c, zc_c;
	logic [13:0] a_c;
	logic [15:0] b_c;
	logic [DIV_W:0] drem_sh, dden;
	logic [15:0] hd_c;
	logic signed [16:0] e0_c, e1_c;
	logic signed [14:0] e2_c;
	logic fold_c;
	logic [13:0] aerr_c;
	logic signed [23:0] prod_c, pw_c;
	logic signed [21:0] sp_c, suml_c, sumr_c;

	function automatic logic signed [CX_W-1:0] shr_s(input logic signed [CX_W-1:0] v,
		input logic [3:0] s);
		shr_s = v[CX_W-1] ? -((-v) >>> s) : (v >>> s);
	endfunction

	function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
		if (v > 22'sd524287) sat20 = 20'sd524287;
		else if (v < -22'sd524288) sat20 = -20'sd524288;
		else sat20 = 20'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			gain_q <= GAIN_RST;
			tol_q <= TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data[9:0];
				CFG_GAIN: gain_q <= cfg_data[7:0];
				CFG_TOL: tol_q <= cfg_data;
				default: radius_q <= radius_q;
			endcase
		end
	end

	assign rd_addr = cmd.rd_p ? tgt_q - IDX_W'(1) : tgt_q;

	always_ff @(posedge clk) begin
		if (cmd.do_load) mem[count_q[IDX_W-1:0]] <= {item_q.wp_time_s, item_q.wp_x_mm,
			item_q.wp_y_mm};
		if (cmd.rd_p || cmd.rd_q) rd_q <= mem[rd_addr];
	end

	always_comb begin
		dx_c = $signed({rd_q[31], rd_q[31:16]}) - $signed({p_q[31], p_q[31:16]});
		dy_c = $signed({rd_q[15], rd_q[15:0]}) - $signed({p_q[15], p_q[15:0]});
		ax_c = dx_c[16] ? -dx_c : dx_c;
		ay_c = dy_c[16] ? -dy_c : dy_c;

		srem_sh = {srem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		strial = REM_W'({root_q, 2'b01});

		xs_c = shr_s(cx_q, cnt_q[3:0]);
		ys_c = shr_s(cy_q, cnt_q[3:0]);
		atan_c = $signed(Z_W'(atan_entry(cnt_q[3:0])));

		if (cz_q < 0) zc_c = '0;
		else if (cz_q > Z_MAX) zc_c = Z_MAX;
		else zc_c = cz_q;
		a_c = 14'((zc_c + Z_W'(128)) >>> 8);
		if (!dxneg_q) b_c = dyneg_q ? 16'd18000 - 16'(a_c) : 16'(a_c);
		else b_c = dyneg_q ? 16'd18000 + 16'(a_c) : 16'd36000 - 16'(a_c);
		if (b_c >= 16'd36000) b_c = b_c - 16'd36000;

		drem_sh = {drem_q[DIV_W-1:0], dvd_q[DIV_W-1]};
		dden = (DIV_W+1)'(den_q);

		hd_c = (item_q.heading_cdeg >= 16'd36000) ? item_q.heading_cdeg - 16'd36000
			: item_q.heading_cdeg;
		e0_c = $signed({1'b0, bearing_q}) - $signed({1'b0, hd_c});
		if (e0_c > 17'sd18000) e1_c = e0_c - 17'sd36000;
		else if (e0_c < -17'sd18000) e1_c = e0_c + 17'sd36000;
		else e1_c = e0_c;
		fold_c = 1'b0;
		if (e1_c > 17'sd9000) begin
			e2_c = 15'(e1_c - 17'sd18000);
			fold_c = 1'b1;
		end else if (e1_c < -17'sd9000) begin
			e2_c = 15'(e1_c + 17'sd18000);
			fold_c = 1'b1;
		end else begin
			e2_c = 15'(e1_c);
		end
		aerr_c = e2_c[14] ? 14'(-e2_c) : 14'(e2_c);

		prod_c = 24'(err_q) * $signed({16'b0, gain_q});
		pw_c = prod_c[23] ? ((prod_c + 24'sd15) >>> 4) : (prod_c >>> 4);

		sp_c = reversed_q ? -$signed({2'b0, speed_q}) : $signed({2'b0, speed_q});
		suml_c = sp_c + 22'(power_q);
		sumr_c = sp_c - 22'(power_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tgt_q <= '0;
			start_q <= '0;
			bearing_q <= '0;
			speed_q <= '0;
			reversed_q <= 1'b0;
			running_q <= 1'b0;
			done_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.do_load) count_q <= count_q + CNT_W'(1);
			if (cmd.do_start) begin
				start_q <= item_q.now_ms;
				tgt_q <= IDX_W'(1);
				reversed_q <= 1'b0;
				done_q <= 1'b0;
				running_q <= 1'b1;
			end
			if (cmd.do_advance) begin
				tgt_q <= tgt_q + IDX_W'(1);
				reversed_q <= 1'b0;
			end
			if (cmd.do_done) done_q <= 1'b1;
			if (cmd.mul1) bearing_q <= b_c;
			if (cmd.speed) speed_q <= (quo_q > DIV_W'(SAT_HI)) ? SAT_HI : quo_q[19:0];
			if (cmd.steer && fold_c) reversed_q <= 1'b1;
			if (cmd.res_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
		if (cmd.do_load) last_t_q <= item_q.wp_time_s;
		if (cmd.rd_q) p_q <= rd_q;
		if (cmd.prep) begin
			ax_q <= ax_c[15:0];
			ay_q <= ay_c[15:0];
			dxneg_q <= dx_c[16];
			dyneg_q <= dy_c[16];
			dur_q <= rd_q[47:32] - p_q[47:32];
			tms_q <= 27'(rd_q[47:32]) * 27'(MS_PER_S);
		end
		if (cmd.sq) begin
			rad_q <= RAD_W'({33'(ax_q) * 33'(ax_q) + 33'(ay_q) * 33'(ay_q), 16'b0});
			srem_q <= '0;
			root_q <= '0;
			cx_q <= CX_W'({ay_q, 12'b0});
			cy_q <= CX_W'({ax_q, 12'b0});
			cz_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.calc) begin
			rad_q <= rad_q << 2;
			if (srem_sh >= strial) begin
				srem_q <= srem_sh - strial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
			if (cnt_q < STEP_W'(CORDIC_STEPS)) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys_c;
					cy_q <= cy_q - xs_c;
					cz_q <= cz_q + atan_c;
				end else begin
					cx_q <= cx_q - ys_c;
					cy_q <= cy_q + xs_c;
					cz_q <= cz_q - atan_c;
				end
			end
			cnt_q <= cnt_q + STEP_W'(1);
		end
		if (cmd.mul1) num_q <= 46'(root_q) * 46'(SPEED_SCALE);
		if (cmd.mul2) rr_q <= 29'(TWO_PI_Q16) * 29'(radius_q);
		if (cmd.mul3) den_q <= 45'(rr_q) * 45'(dur_q);
		if (cmd.div_init) begin
			dvd_q <= DIV_W'(num_q) + DIV_W'(den_q >> 1);
			drem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			if (drem_sh >= dden) begin
				drem_q <= drem_sh - dden;
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + STEP_W'(1);
		end
		if (cmd.steer) begin
			err_q <= e2_c;
			drive_q <= aerr_c < tol_q;
		end
		if (cmd.power) power_q <= 20'(pw_c);
		if (cmd.set_code) begin
			code_q <= cmd.code;
			steer_q <= cmd.code_steer;
		end
		if (cmd.res_load) begin
			if (steer_q && drive_q) begin
				out_item.left_drive <= sat20(suml_c);
				out_item.right_drive <= sat20(sumr_c);
				out_item.status <= RES_DRIVE;
			end else if (steer_q) begin
				out_item.left_drive <= sat20(22'(power_q));
				out_item.right_drive <= sat20(-22'(power_q));
				out_item.status <= RES_TURN;
			end else begin
				out_item.left_drive <= '0;
				out_item.right_drive <= '0;
				out_item.status <= code_q;
			end
		end
	end

	always_comb begin
		sts.req_type = item_q.req_type;
		sts.running = running_q;
		sts.done = done_q;
		sts.load_ok = !running_q && (count_q < CNT_W'(MAX_WAYPOINTS)) &&
			((count_q == '0) || (item_q.wp_time_s > last_t_q));
		sts.start_ok = !running_q && (count_q >= CNT_W'(2));
		sts.reached = (item_q.now_ms - start_q) >= 32'(tms_q);
		sts.at_end = (CNT_W'(tgt_q) + CNT_W'(1)) >= count_q;
		sts.sqrt_last = (cnt_q == STEP_W'(SQRT_STEPS - 1));
		sts.div_last = (cnt_q == STEP_W'(DIV_W - 1));
		sts.out_busy = out_valid && !out_ready;
	end

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> count_q >= CNT_W'(2)) else $error("running with short table");
	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> running_q) else $error("done without running");
	a_tgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> CNT_W'(tgt_q) < count_q) else $error("target beyond table");
	a_res_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid) else $error("result not presented");

endmodule

// File: sim/tb.sv
// Self-checking testbench for timed_waypoint_drive_follower_core.
// Drives loads, starts and control ticks through valid/ready with random idling,
// predicts every result in SystemVerilog and compares it field by field; needs twdf_pkg.
module tb;
	import twdf_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam longint unsigned SPEED_SAT = 64'd524287;
	localparam longint ATAN_STEP [16] = '{1152000, 680065, 359328, 182400, 91554, 45822,
		22916, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};

	typedef struct {
		in_item_t it;
		bit typed;
		out_item_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [13:0] cfg_data = '0;

	int errors = 0;
	int sender_idle = 0;
	int receiver_stall = 0;
	int hold_cycles = 0;
	out_item_t drive_q [$];
	row_t rows [$];

	// predicted state of the follower
	int unsigned wp_t [MAX_WAYPOINTS];
	int wp_x [MAX_WAYPOINTS];
	int wp_y [MAX_WAYPOINTS];
	int unsigned wp_cnt = 0, tgt_idx = 0, bearing = 0;
	bit [31:0] start_ms = '0;
	longint seg_speed = 0;
	bit rev = 0, running = 0, finished = 0;
	int unsigned radius = RADIUS_RST, gain = GAIN_RST, tol = TOL_RST;

	bit [31:0] path_t0;
	bit [31:0] elapsed_ms;
	int unsigned last_t;

	timed_waypoint_drive_follower_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint shr_sym(longint v, int s);
		return v < 0 ? -((-v) >>> s) : (v >>> s);
	endfunction

	function automatic logic signed [19:0] sat20(longint v);
		if (v > 524287) return 20'sd524287;
		if (v < -524288) return -20'sd524288;
		return v[19:0];
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int unsigned quadrant_angle(longint a, longint b);
		longint x, y, z, xs, ys;
		x = a * 4096;
		y = b * 4096;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			xs = shr_sym(x, i);
			ys = shr_sym(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_STEP[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_STEP[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 2304000) z = 2304000;
		return int'((z + 128) / 256);
	endfunction

	function automatic void aim_segment(int unsigned idx);
		int unsigned pi, qi, a, b;
		longint dx, dy, ax, ay;
		longint unsigned len, num, den, dur, s;
		bit [31:0] dt;
		pi = (idx - 1) % MAX_WAYPOINTS;
		qi = idx % MAX_WAYPOINTS;
		dx = longint'(wp_x[qi]) - wp_x[pi];
		dy = longint'(wp_y[qi]) - wp_y[pi];
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		a = quadrant_angle(ay, ax);
		if (dx >= 0) b = (dy >= 0) ? a : 18000 - a;
		else b = (dy < 0) ? 18000 + a : 36000 - a;
		if (b >= 36000) b -= 36000;
		bearing = b;
		len = root_floor(longint'(ax * ax + ay * ay) << 16);
		num = len * 64'd1536000;
		dt = wp_t[qi] - wp_t[pi];
		dur = dt;
		den = 64'd411775 * radius * dur;
		s = (den == 0) ? SPEED_SAT : (num + den / 2) / den;
		seg_speed = (s > SPEED_SAT) ? SPEED_SAT : s;
	endfunction

	function automatic out_item_t predict_drive(in_item_t it);
		out_item_t r;
		bit [31:0] el;
		int unsigned secs;
		int hd, err, aerr;
		longint power, sp;
		bit steer;
		r = '0;
		r.status = RES_IDLE;
		case (it.req_type)
			REQ_LOAD: begin
				if (running || wp_cnt >= MAX_WAYPOINTS ||
						(wp_cnt > 0 && it.wp_time_s <= wp_t[wp_cnt - 1])) begin
					r.status = RES_REJECT;
				end else begin
					wp_t[wp_cnt] = it.wp_time_s;
					wp_x[wp_cnt] = it.wp_x_mm;
					wp_y[wp_cnt] = it.wp_y_mm;
					wp_cnt++;
				end
			end
			REQ_START: begin
				if (running || wp_cnt < 2) begin
					r.status = RES_REJECT;
				end else begin
					start_ms = it.now_ms;
					tgt_idx = 1;
					rev = 0;
					finished = 0;
					running = 1;
					aim_segment(1);
				end
			end
			REQ_TICK: begin
				if (running && finished) begin
					r.status = RES_DONE;
				end else if (running) begin
					el = it.now_ms - start_ms;
					secs = el / 1000;
					steer = 1;
					if (secs >= wp_t[tgt_idx % MAX_WAYPOINTS]) begin
						if (tgt_idx + 1 >= wp_cnt) begin
							finished = 1;
							r.status = RES_DONE;
							steer = 0;
						end else begin
							tgt_idx++;
							aim_segment(tgt_idx);
							rev = 0;
						end
					end
					if (steer) begin
						hd = it.heading_cdeg % 36000;
						err = int'(bearing) - hd;
						if (err > 18000) err -= 36000;
						else if (err < -18000) err += 36000;
						if (err > 9000) begin
							err -= 18000; rev = 1;
						end else if (err < -9000) begin
							err += 18000; rev = 1;
						end
						power = (longint'(err) * longint'(gain)) / 16;
						aerr = err < 0 ? -err : err;
						if (aerr < int'(tol)) begin
							sp = rev ? -seg_speed : seg_speed;
							r.left_drive = sat20(sp + power);
							r.right_drive = sat20(sp - power);
							r.status = RES_DRIVE;
						end else begin
							r.left_drive = sat20(power);
							r.right_drive = sat20(-power);
							r.status = RES_TURN;
						end
					end
				end
			end
			default: r.status = RES_REJECT;
		endcase
		return r;
	endfunction

	function automatic in_item_t mk(logic [1:0] req, logic [15:0] t, logic [15:0] x,
			logic [15:0] y, logic [15:0] hd, logic [31:0] now);
		in_item_t it;
		it.req_type = req;
		it.wp_time_s = t;
		it.wp_x_mm = x;
		it.wp_y_mm = y;
		it.heading_cdeg = hd;
		it.now_ms = now;
		return it;
	endfunction

	function automatic out_item_t res(logic signed [19:0] l, logic signed [19:0] r,
			logic [2:0] s);
		out_item_t o;
		o.left_drive = l;
		o.right_drive = r;
		o.status = s;
		return o;
	endfunction

	task automatic send(in_item_t it, bit typed, out_item_t typed_res);
		out_item_t p;
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = predict_drive(it);
		drive_q.push_back(typed ? typed_res : p);
	endtask

	task automatic push(in_item_t it);
		send(it, 1'b0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [13:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_RADIUS: radius = val[9:0];
			CFG_GAIN: gain = val[7:0];
			CFG_TOL: tol = val;
			default: ;
		endcase
	endtask

	task automatic tick_or_noise();
		logic [15:0] hd;
		int off;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(2))
				0: push(mk(REQ_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom));
				1: push(mk(REQ_START, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom));
				default: push(mk(REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom));
			endcase
		end else begin
			elapsed_ms += ($urandom_range(9) == 0) ? $urandom_range(3000) : $urandom_range(600);
			if ($urandom_range(1) == 0) begin
				hd = 16'($urandom);
			end else begin
				off = int'($urandom_range(1600)) - 800 + ($urandom_range(1) ? 18000 : 0);
				hd = 16'((int'(bearing) + 72000 + off) % 36000);
			end
			push(mk(REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom), hd,
				path_t0 + elapsed_ms));
		end
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (drive_q.size() == 0) begin
				$error("unexpected item: left %0d right %0d status %0d",
					out_item.left_drive, out_item.right_drive, out_item.status);
				errors++;
			end else begin
				e = drive_q.pop_front();
				if (out_item.left_drive !== e.left_drive) begin
					$error("left_drive: expected %0d, got %0d", e.left_drive, out_item.left_drive);
					errors++;
				end
				if (out_item.right_drive !== e.right_drive) begin
					$error("right_drive: expected %0d, got %0d", e.right_drive,
						out_item.right_drive);
					errors++;
				end
				if (out_item.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, out_item.status);
					errors++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{mk(REQ_TICK, 0, 0, 0, 16'hFFFF, '1), 1, res(0, 0, RES_IDLE)});
		rows.push_back('{mk(REQ_UNUSED, '1, '1, '1, '1, '1), 1, res(0, 0, RES_REJECT)});
		rows.push_back('{mk(REQ_START, 0, 0, 0, 0, 0), 1, res(0, 0, RES_REJECT)});
		rows.push_back('{mk(REQ_LOAD, 0, 16'h8000, 16'h8000, 0, 0), 1, res(0, 0, RES_IDLE)});
		rows.push_back('{mk(REQ_START, 0, 0, 0, 0, 5), 1, res(0, 0, RES_REJECT)});
		rows.push_back('{mk(REQ_LOAD, 0, 0, 0, 0, 0), 1, res(0, 0, RES_REJECT)});
		rows.push_back('{mk(REQ_LOAD, 2, 16'h7FFF, 16'h7FFF, 0, 0), 1, res(0, 0, RES_IDLE)});
		rows.push_back('{mk(REQ_LOAD, 1, 0, 0, 0, 0), 1, res(0, 0, RES_REJECT)});
		rows.push_back('{mk(REQ_LOAD, 4, 16'h7FFF, 16'h8000, 0, 0), 1, res(0, 0, RES_IDLE)});
		rows.push_back('{mk(REQ_LOAD, 5, 0, 0, 0, 0), 1, res(0, 0, RES_IDLE)});
		rows.push_back('{mk(REQ_LOAD, 6, 16'h8000, 16'h7FFF, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_LOAD, 7, 0, 16'h8000, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_LOAD, 8, 0, 0, 0, 0), 0, '0});
		foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);

		// fill the table with short, timed segments
		last_t = 8;
		while (wp_cnt < MAX_WAYPOINTS) begin
			last_t += $urandom_range(1, 4);
			if ($urandom_range(7) == 0)
				push(mk(REQ_LOAD, 16'(last_t), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom));
			else
				push(mk(REQ_LOAD, 16'(last_t), 16'($urandom_range(4000) - 2000),
					16'($urandom_range(4000) - 2000), 16'($urandom), $urandom));
		end
		send(mk(REQ_LOAD, 16'(last_t + 1), 0, 0, 0, 0), 1, res(0, 0, RES_REJECT));
		send(mk(REQ_LOAD, '1, 0, 0, 0, 0), 1, res(0, 0, RES_REJECT));

		path_t0 = 32'hFFFF_0000 + $urandom_range(60000);
		elapsed_ms = 0;
		push(mk(REQ_START, 0, 0, 0, 0, path_t0));
		repeat (120) tick_or_noise();
		drain();

		sender_idle = 60;
		write_reg(CFG_RADIUS, 14'd1);
		write_reg(CFG_GAIN, 14'd255);
		write_reg(CFG_TOL, 14'd16383);
		repeat (120) tick_or_noise();
		drain();

		sender_idle = 0;
		receiver_stall = 60;
		write_reg(CFG_RADIUS, 14'd1023);
		write_reg(CFG_GAIN, 14'd0);
		write_reg(CFG_TOL, 14'd0);
		hold_cycles = 400;
		repeat (120) tick_or_noise();
		drain();

		sender_idle = 34;
		receiver_stall = 34;
		write_reg(CFG_RADIUS, 14'd0);
		write_reg(CFG_GAIN, 14'd16);
		write_reg(CFG_TOL, 14'd9000);
		repeat (120) tick_or_noise();
		drain();

		sender_idle = 0;
		receiver_stall = 0;
		write_reg(CFG_RADIUS, 14'($urandom_range(1, 1000)));
		write_reg(CFG_GAIN, 14'($urandom_range(255)));
		write_reg(CFG_TOL, 14'($urandom_range(9000)));
		repeat (100) tick_or_noise();
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
